>>> design/sbc_pkg.sv
// sbc_pkg: shared types, widths and codes for the swept box tile clip block
// no dependencies; imported by the clip top level and the divider

package sbc_pkg;

   // fixed field widths
   localparam int SBC_W  = 35;   // working width of fixed point coordinates
   localparam int IDX_W  = 9;    // signed cell index, grid is at most 127 wide
   localparam int CFG_W  = 7;    // grid size registers
   localparam int AV_W   = 32;   // magnitude of a velocity component
   localparam int POS_W  = 32;
   localparam int SIZE_W = 31;
   localparam int REQ_W  = 208;
   localparam int RSP_W  = 72;

   // module parameter defaults
   localparam int MAX_WIDTH_DEF  = 64;
   localparam int MAX_HEIGHT_DEF = 64;
   localparam int FRAC_BITS_DEF  = 16;

   typedef logic signed [SBC_W-1:0] fix_type;
   typedef logic signed [IDX_W-1:0] idx_type;

   // actions
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLIP  = 2'd2;

   // tile kinds
   localparam logic [1:0] KIND_EMPTY  = 2'd0;
   localparam logic [1:0] KIND_SOLID  = 2'd1;
   localparam logic [1:0] KIND_ONEWAY = 2'd2;
   localparam logic [1:0] KIND_BAD    = 2'd3;

   // outcomes
   localparam logic [1:0] OC_NONE  = 2'd0;
   localparam logic [1:0] OC_VLINE = 2'd1;
   localparam logic [1:0] OC_HLINE = 2'd2;

   // register indexes
   localparam logic [0:0] REG_WIDTH  = 1'b0;
   localparam logic [0:0] REG_HEIGHT = 1'b1;

   // one axis of the sweep walk
   typedef struct packed {
      logic              reach;
      logic              vpos;
      logic              vneg;
      idx_type           idx;
      idx_type           last;
      idx_type           line;
      fix_type           front;
      fix_type           orig;
      logic [SIZE_W-1:0] size;
      logic [AV_W-1:0]   av;
   } axis_type;

   typedef enum logic [17:0] {
      S_CLEAR      = 18'h00001,
      S_IDLE       = 18'h00002,
      S_READ       = 18'h00004,
      S_SETUP_X    = 18'h00008,
      S_SETUP_Y    = 18'h00010,
      S_NEED       = 18'h00020,
      S_CORNER_RD  = 18'h00040,
      S_CORNER_CHK = 18'h00080,
      S_MUL_A      = 18'h00100,
      S_MUL_B      = 18'h00200,
      S_ORDER      = 18'h00400,
      S_SHIFT_MUL  = 18'h00800,
      S_DIV_GO     = 18'h01000,
      S_DIV        = 18'h02000,
      S_APPLY      = 18'h04000,
      S_SPAN       = 18'h08000,
      S_SCAN_RD    = 18'h10000,
      S_SCAN_CHK   = 18'h20000
   } state_type;

endpackage

>>> design/swept_box_tile_grid_clip.sv
// swept_box_tile_grid_clip: tile grid store and swept rectangle clip engine
// depends on sbc_pkg, sbc_ram and sbc_div
//
//   channel   dir  handshake             payload
//   req_      in   req_tvalid/tready     tuser action, tdata query fields
//   rsp_      out  rsp_tvalid/tready     tdata read kind, move, outcome
//   csr_      in   csr_we                csr_addr register, csr_wdata value
//
// A write is answered from idle and a read passes through the read state. A
// clip runs the setup of both axes, then per line crossing a multiply and a
// divide on the shared divider, plus a read and a check per tile scanned through the single grid read port.
// After reset the grid memory is swept to empty, one tile a cycle over all
// 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) tiles, with req_tready low.
// One word is worked on at a time; a finished word waits in the output
// register, and the next word is taken no earlier than the cycle it leaves.

module swept_box_tile_grid_clip
   import sbc_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // cell_x, cell_y, cell_kind, pos_x, pos_y, size_x, size_y, vel_x, vel_y,
   // prefer_vertical, zero fill
   input  logic [REQ_W-1:0] req_tdata,
   // action
   input  logic [1:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // read_kind, move_x, move_y, outcome, zero fill
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_we,
   input  logic [0:0]       csr_addr,
   input  logic [CFG_W-1:0] csr_wdata
);

   localparam int XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int AW = XW + YW;
   localparam int DEPTH = 1 << AW;
   localparam logic [CFG_W-1:0] GW_RST = CFG_W'((MAX_WIDTH  < 64) ? MAX_WIDTH  : 64);
   localparam logic [CFG_W-1:0] GH_RST = CFG_W'((MAX_HEIGHT < 64) ? MAX_HEIGHT : 64);
   localparam fix_type RND = fix_type'((64'sd1 <<< FRAC_BITS) - 64'sd1);

   // request fields
   logic [1:0]        f_action;
   logic [5:0]        f_cx, f_cy;
   logic [1:0]        f_kind;
   logic [POS_W-1:0]  f_px, f_py, f_vx, f_vy;
   logic [SIZE_W-1:0] f_sx, f_sy;
   logic              f_pref;

   assign f_action = req_tuser;
   assign f_cx     = req_tdata[5:0];
   assign f_cy     = req_tdata[11:6];
   assign f_kind   = req_tdata[13:12];
   assign f_px     = req_tdata[45:14];
   assign f_py     = req_tdata[77:46];
   assign f_sx     = req_tdata[108:78];
   assign f_sy     = req_tdata[139:109];
   assign f_vx     = req_tdata[171:140];
   assign f_vy     = req_tdata[203:172];
   assign f_pref   = req_tdata[204];

   // registers
   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  gw_ff, gw_in, gh_ff, gh_in;
   logic [AW-1:0]     clr_ff, clr_in;
   axis_type          ax_ff, ax_in, ay_ff, ay_in;
   logic [POS_W-1:0]  px_ff, px_in, py_ff, py_in, vx_ff, vx_in, vy_ff, vy_in;
   logic [SIZE_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic              pref_ff, pref_in;
   logic [AV_W-1:0]   nx_ff, nx_in, ny_ff, ny_in;
   logic [2*AV_W-1:0] prod_ff, prod_in, lx_ff, lx_in;
   logic              tx_ff, tx_in;
   idx_type           k_ff, k_in, hi_ff, hi_in;
   logic              rd_ok_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in, rsp_oc_ff, rsp_oc_in;
   logic [POS_W-1:0]  rsp_mx_ff, rsp_mx_in, rsp_my_ff, rsp_my_in;

   // memory and divider hookup
   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [1:0]        ram_wdata, ram_q, tile_val;
   idx_type           rd_x, rd_y;
   logic              rd_ok;
   logic              div_start, div_done;
   logic [AV_W-1:0]   div_q, div_d;
   logic [AV_W-1:0]   mul_a, mul_b;
   logic [2*AV_W-1:0] mul_p;

   // setup unit, shared between the two axes
   logic [POS_W-1:0]  su_p, su_v;
   logic [SIZE_W-1:0] su_s;
   logic [CFG_W-1:0]  su_max;
   axis_type          su_ax;
   logic              su_ok;

   // need and span helpers
   logic [AV_W-1:0]   need_x, need_y;
   idx_type           span_lo, span_hi;
   logic              accept, stop;
   idx_type           gw_s, gh_s;

   function automatic logic [AW-1:0] addr_of(idx_type x, idx_type y);
      logic [10:0] xe, ye;
      xe = {4'b0, x[6:0]};
      ye = {4'b0, y[6:0]};
      return {ye[YW-1:0], xe[XW-1:0]};
   endfunction

   function automatic logic [CFG_W-1:0] cfg_fix(logic [CFG_W-1:0] v, int unsigned lim);
      logic [CFG_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (32'(v) > lim) begin
         r = CFG_W'(lim);
      end
      return r;
   endfunction

   function automatic fix_type ext_av(logic [AV_W-1:0] av);
      return fix_type'({{(SBC_W-AV_W){1'b0}}, av});
   endfunction

   // distance from the front to the next line along the motion, clamped
   function automatic logic [AV_W-1:0] need_of(axis_type a);
      fix_type n;
      logic [AV_W-1:0] r;
      n = (fix_type'(a.line) <<< FRAC_BITS) - a.front;
      if (a.vneg) begin
         n = -n;
      end
      if (n < 0) begin
         r = '0;
      end else if (n > ext_av(a.av)) begin
         r = a.av;
      end else begin
         r = n[AV_W-1:0];
      end
      return r;
   endfunction

   function automatic axis_type advance(axis_type a);
      axis_type r;
      r = a;
      if (a.vneg) begin
         r.line = a.line - idx_type'(1);
         r.idx  = a.idx - idx_type'(1);
         if (r.idx < a.last) r.reach = 1'b0;
      end else begin
         r.line = a.line + idx_type'(1);
         r.idx  = a.idx + idx_type'(1);
         if (r.idx > a.last) r.reach = 1'b0;
      end
      return r;
   endfunction

   assign gw_s = $signed({2'b00, gw_ff});
   assign gh_s = $signed({2'b00, gh_ff});

   // axis setup: reachable line range, start front and velocity magnitude
   always_comb begin
      fix_type p, s, v, mx, e0, e1, r0, r1, r0c, r1c;
      p  = fix_type'($signed(su_p));
      s  = fix_type'({{(SBC_W-SIZE_W){1'b0}}, su_s});
      v  = fix_type'($signed(su_v));
      mx = fix_type'({{(SBC_W-CFG_W){1'b0}}, su_max});
      su_ax = '0;
      su_ax.vneg = v < 0;
      su_ax.vpos = v > 0;
      if (!su_ax.vneg) begin
         e0  = p + s;
         e1  = e0 + v;
         r0  = (e0 + RND) >>> FRAC_BITS;
         r1  = ((e1 + RND) >>> FRAC_BITS) - fix_type'(1);
         su_ok = !(r0 >= mx || r1 < 0);
         r0c = (r0 < 0) ? fix_type'(0) : r0;
         r1c = (r1 >= mx) ? mx - fix_type'(1) : r1;
         su_ax.line  = r0c[IDX_W-1:0];
         su_ax.reach = su_ax.vpos && (r0c <= r1c);
      end else begin
         e0  = p;
         e1  = p + v;
         r0  = (e0 >>> FRAC_BITS) - fix_type'(1);
         r1  = e1 >>> FRAC_BITS;
         su_ok = !(r0 < 0 || r1 >= mx);
         r0c = (r0 >= mx) ? mx - fix_type'(1) : r0;
         r1c = (r1 < 0) ? fix_type'(0) : r1;
         su_ax.line  = idx_type'(r0c[IDX_W-1:0]) + idx_type'(1);
         su_ax.reach = r0c >= r1c;
      end
      su_ax.idx   = r0c[IDX_W-1:0];
      su_ax.last  = r1c[IDX_W-1:0];
      su_ax.av    = su_ax.vneg ? AV_W'(-v) : v[AV_W-1:0];
      su_ax.front = su_ax.vpos ? p + s : p;
      su_ax.orig  = su_ax.front;
      su_ax.size  = su_s;
   end

   // setup operand select
   always_comb begin
      if (state_ff == S_SETUP_X) begin
         su_p = px_ff; su_s = sx_ff; su_v = vx_ff; su_max = gw_ff;
      end else begin
         su_p = py_ff; su_s = sy_ff; su_v = vy_ff; su_max = gh_ff;
      end
   end

   assign need_x = need_of(ax_ff);
   assign need_y = need_of(ay_ff);

   // tiles behind the leading edge of the other axis
   always_comb begin
      axis_type o;
      fix_type  lo, hi, lim, s;
      o   = tx_ff ? ay_ff : ax_ff;
      lim = tx_ff ? fix_type'({{(SBC_W-CFG_W){1'b0}}, gh_ff})
                  : fix_type'({{(SBC_W-CFG_W){1'b0}}, gw_ff});
      s   = fix_type'({{(SBC_W-SIZE_W){1'b0}}, o.size});
      lo  = (o.front - (o.vpos ? s : fix_type'(0))) >>> FRAC_BITS;
      hi  = ((o.front + (o.vpos ? fix_type'(0) : s) + RND) >>> FRAC_BITS) - fix_type'(1);
      if (lo < 0)   lo = '0;
      if (lo > lim) lo = lim;
      if (hi > lim - fix_type'(1)) hi = lim - fix_type'(1);
      if (hi < -1)  hi = fix_type'(-1);
      span_lo = lo[IDX_W-1:0];
      span_hi = hi[IDX_W-1:0];
   end

   // shared multiplier operands
   always_comb begin
      case (state_ff)
         S_MUL_A: begin
            mul_a = nx_ff; mul_b = ay_ff.av;
         end
         S_MUL_B: begin
            mul_a = ny_ff; mul_b = ax_ff.av;
         end
         default: begin
            mul_a = tx_ff ? nx_ff : ny_ff;
            mul_b = tx_ff ? ay_ff.av : ax_ff.av;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;
   assign div_d = tx_ff ? ax_ff.av : ay_ff.av;

   // grid read address and bounds
   always_comb begin
      case (state_ff)
         S_CORNER_RD: begin
            rd_x = ax_ff.idx; rd_y = ay_ff.idx;
         end
         S_SCAN_RD: begin
            rd_x = tx_ff ? ax_ff.idx : k_ff;
            rd_y = tx_ff ? k_ff : ay_ff.idx;
         end
         default: begin
            rd_x = idx_type'({3'b0, f_cx});
            rd_y = idx_type'({3'b0, f_cy});
         end
      endcase
      rd_ok = rd_x >= 0 && rd_y >= 0 && rd_x < gw_s && rd_y < gh_s;
   end
   assign ram_raddr = addr_of(rd_x, rd_y);
   assign tile_val  = rd_ok_ff ? ram_q : KIND_EMPTY;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);

   // stop test for the tile just read
   always_comb begin
      if (state_ff == S_SCAN_CHK && tx_ff) begin
         stop = tile_val == KIND_SOLID;
      end else begin
         stop = tile_val == KIND_SOLID || (tile_val == KIND_ONEWAY && ay_ff.vpos);
      end
   end

   // sequencer
   always_comb begin
      axis_type o;
      state_in     = state_ff;
      gw_in        = gw_ff;
      gh_in        = gh_ff;
      clr_in       = clr_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      px_in        = px_ff; py_in = py_ff; vx_in = vx_ff; vy_in = vy_ff;
      sx_in        = sx_ff; sy_in = sy_ff; pref_in = pref_ff;
      nx_in        = nx_ff; ny_in = ny_ff;
      prod_in      = prod_ff;
      lx_in        = lx_ff;
      tx_in        = tx_ff;
      k_in         = k_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_oc_in    = rsp_oc_ff;
      rsp_mx_in    = rsp_mx_ff;
      rsp_my_in    = rsp_my_ff;
      ram_we       = 1'b0;
      ram_waddr    = addr_of(idx_type'({3'b0, f_cx}), idx_type'({3'b0, f_cy}));
      ram_wdata    = (f_kind == KIND_BAD) ? KIND_EMPTY : f_kind;
      div_start    = 1'b0;
      o            = '0;

      // configuration writes
      if (csr_we) begin
         case (csr_addr)
            REG_WIDTH:  gw_in = cfg_fix(csr_wdata, MAX_WIDTH);
            REG_HEIGHT: gh_in = cfg_fix(csr_wdata, MAX_HEIGHT);
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = KIND_EMPTY;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               rsp_kind_in = KIND_EMPTY;
               rsp_oc_in   = OC_NONE;
               rsp_mx_in   = '0;
               rsp_my_in   = '0;
               px_in = f_px; py_in = f_py; vx_in = f_vx; vy_in = f_vy;
               sx_in = f_sx; sy_in = f_sy; pref_in = f_pref;
               case (f_action)
                  ACT_WRITE: begin
                     ram_we       = rd_ok;
                     rsp_valid_in = 1'b1;
                  end
                  ACT_READ: state_in = S_READ;
                  ACT_CLIP: state_in = S_SETUP_X;
                  default:  rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_READ: begin
            rsp_kind_in  = tile_val;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_SETUP_X, S_SETUP_Y: begin
            if (state_ff == S_SETUP_X) ax_in = su_ax;
            else ay_in = su_ax;
            if (!su_ok) begin
               rsp_mx_in    = vx_ff;
               rsp_my_in    = vy_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = (state_ff == S_SETUP_X) ? S_SETUP_Y : S_NEED;
            end
         end
         S_NEED: begin
            nx_in = need_x;
            ny_in = need_y;
            if (!ax_ff.reach && !ay_ff.reach) begin
               rsp_mx_in    = vx_ff;
               rsp_my_in    = vy_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (ax_ff.reach && ay_ff.reach) begin
               state_in = (need_x == '0 && need_y == '0) ? S_CORNER_RD : S_MUL_A;
            end else begin
               tx_in    = ax_ff.reach;
               state_in = S_SHIFT_MUL;
            end
         end
         S_CORNER_RD: state_in = S_CORNER_CHK;
         S_CORNER_CHK: begin
            if (stop) begin
               rsp_mx_in    = POS_W'(ax_ff.front - ax_ff.orig);
               rsp_my_in    = POS_W'(ay_ff.front - ay_ff.orig);
               rsp_oc_in    = pref_ff ? OC_VLINE : OC_HLINE;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_MUL_A;
            end
         end
         S_MUL_A: begin
            prod_in  = mul_p;
            state_in = S_MUL_B;
         end
         S_MUL_B: begin
            lx_in    = prod_ff;
            prod_in  = mul_p;
            state_in = S_ORDER;
         end
         S_ORDER: begin
            tx_in    = (lx_ff < prod_ff) || (lx_ff == prod_ff && pref_ff);
            state_in = S_SHIFT_MUL;
         end
         S_SHIFT_MUL: begin
            prod_in  = mul_p;
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) state_in = S_APPLY;
         end
         S_APPLY: begin
            // shift the other front, put the taker on its line
            o = tx_ff ? ay_ff : ax_ff;
            if (o.vpos) o.front = o.front + ext_av(div_q);
            else o.front = o.front - ext_av(div_q);
            if (tx_ff) begin
               ay_in       = o;
               ax_in.front = fix_type'(ax_ff.line) <<< FRAC_BITS;
            end else begin
               ax_in       = o;
               ay_in.front = fix_type'(ay_ff.line) <<< FRAC_BITS;
            end
            state_in = S_SPAN;
         end
         S_SPAN: begin
            k_in     = span_lo;
            hi_in    = span_hi;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            if (k_ff > hi_ff) begin
               if (tx_ff) ax_in = advance(ax_ff);
               else ay_in = advance(ay_ff);
               state_in = S_NEED;
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (stop) begin
               rsp_mx_in    = POS_W'(ax_ff.front - ax_ff.orig);
               rsp_my_in    = POS_W'(ay_ff.front - ay_ff.orig);
               rsp_oc_in    = tx_ff ? OC_VLINE : OC_HLINE;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               k_in     = k_ff + idx_type'(1);
               state_in = S_SCAN_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         gw_ff        <= GW_RST;
         gh_ff        <= GH_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         gw_ff        <= gw_in;
         gh_ff        <= gh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      pref_ff     <= pref_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      prod_ff     <= prod_in;
      lx_ff       <= lx_in;
      tx_ff       <= tx_in;
      k_ff        <= k_in;
      hi_ff       <= hi_in;
      rd_ok_ff    <= rd_ok;
      rsp_kind_ff <= rsp_kind_in;
      rsp_oc_ff   <= rsp_oc_in;
      rsp_mx_ff   <= rsp_mx_in;
      rsp_my_ff   <= rsp_my_in;
   end

   // tile store
   sbc_ram #(
      .WIDTH (2),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_q)
   );

   // crossing shift divider
   sbc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_oc_ff, rsp_my_ff, rsp_mx_ff, rsp_kind_ff};

endmodule

>>> design/sbc_ram.sv
// sbc_ram: generic single write, single read memory with registered read data
// no dependencies

module sbc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/sbc_div.sv
// sbc_div: restoring divider, one quotient bit per cycle
// depends on sbc_pkg; dividend high half must be below the divisor

module sbc_div
   import sbc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [2*AV_W-1:0]   dividend,
   input  logic [AV_W-1:0]     divisor,
   output logic                done,
   output logic [AV_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(AV_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [AV_W-1:0]   rem_ff, rem_in;
   logic [AV_W-1:0]   quo_ff, quo_in;
   logic [AV_W:0]     trial;
   logic              ge;

   // one trial subtract per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[AV_W-1]};
      ge      = trial >= {1'b0, divisor};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend[2*AV_W-1:AV_W];
         quo_in  = dividend[AV_W-1:0];
      end else if (busy_ff) begin
         rem_in = ge ? AV_W'(trial - {1'b0, divisor}) : trial[AV_W-1:0];
         quo_in = {quo_ff[AV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(AV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> tb/sv/swept_box_tile_grid_clip_chk.sv
`timescale 1ns / 100ps
// swept_box_tile_grid_clip_chk: watches the request, response and csr ports,
// predicts each response word from its own tile grid copy and compares; uses sbc_pkg

module swept_box_tile_grid_clip_chk
   import sbc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic [1:0]       req_tuser,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_we,
   input  logic [0:0]       csr_addr,
   input  logic [CFG_W-1:0] csr_wdata,
   output int               errors,
   output int               pending
);

   localparam longint ONE = 64'sd1 <<< FRAC_BITS_DEF;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] mx;
      logic [31:0] my;
      logic [1:0]  oc;
   } clip_word_t;

   typedef struct {
      bit                  reach;
      longint              idx, last, inc, line, front, orig, lo_off, hi_off, v;
      longint unsigned     av;
   } sweep_axis_t;

   logic [1:0]  tiles [MAX_HEIGHT_DEF][MAX_WIDTH_DEF];
   longint      cols, rows;
   clip_word_t  expected_q [$];

   function automatic longint cell_floor(longint a);
      if (a >= 0) return a >>> FRAC_BITS_DEF;
      return -((-a + ONE - 1) >>> FRAC_BITS_DEF);
   endfunction

   function automatic longint cell_ceil(longint a);
      return -cell_floor(-a);
   endfunction

   function automatic logic [1:0] tile_at(longint x, longint y);
      if (x < 0 || y < 0 || x >= cols || y >= rows) return KIND_EMPTY;
      return tiles[y][x];
   endfunction

   // column or row range the sweep reaches on one axis
   function automatic bit axis_open(longint p, longint s, longint v, longint lim,
                                    output sweep_axis_t a);
      longint r0, r1;
      a = '{default: 0};
      if (v >= 0) begin
         r0 = cell_ceil(p + s);
         r1 = cell_ceil(p + s + v) - 1;
         if (r0 >= lim || r1 < 0) return 0;
         if (r0 < 0) r0 = 0;
         if (r1 >= lim) r1 = lim - 1;
         a.line  = r0;
         a.reach = (v > 0) && (r0 <= r1);
         a.inc   = 1;
      end else begin
         r0 = cell_floor(p) - 1;
         r1 = cell_floor(p + v);
         if (r0 < 0 || r1 >= lim) return 0;
         if (r0 >= lim) r0 = lim - 1;
         if (r1 < 0) r1 = 0;
         a.line  = r0 + 1;
         a.reach = (r0 >= r1);
         a.inc   = -1;
      end
      a.idx    = r0;
      a.last   = r1;
      a.v      = v;
      a.av     = (v < 0) ? -v : v;
      a.front  = p + ((v > 0) ? s : 0);
      a.orig   = a.front;
      a.lo_off = (v > 0) ? -s : 0;
      a.hi_off = (v > 0) ? 0 : s;
      return 1;
   endfunction

   // distance to the next grid line along the motion
   function automatic longint unsigned line_gap(sweep_axis_t a);
      longint n;
      n = a.line * ONE - a.front;
      if (a.v < 0) n = -n;
      if (n < 0) n = 0;
      if (longint'(a.av) < n) return a.av;
      return n;
   endfunction

   function automatic void slide(inout sweep_axis_t o, input longint unsigned n,
                                 input longint unsigned d);
      longint unsigned amt;
      if (d == 0) return;
      amt = (n * o.av) / d;
      if (o.v > 0) o.front += longint'(amt);
      else o.front -= longint'(amt);
   endfunction

   function automatic void step_line(inout sweep_axis_t a);
      a.line += a.inc;
      a.idx  += a.inc;
      if ((a.last - a.idx) * a.inc < 0) a.reach = 0;
   endfunction

   function automatic void span_of(sweep_axis_t o, longint lim,
                                   output longint lo, output longint hi);
      lo = cell_floor(o.front + o.lo_off);
      hi = cell_ceil(o.front + o.hi_off) - 1;
      if (lo < 0) lo = 0;
      if (hi > lim - 1) hi = lim - 1;
   endfunction

   // swept rectangle clip; returns the outcome code
   function automatic logic [1:0] clip_sweep(longint px, longint py, longint sx,
                                             longint sy, longint vx, longint vy,
                                             bit pref, output longint mx,
                                             output longint my);
      sweep_axis_t     ax, ay;
      longint          lo, hi;
      longint unsigned nx, ny, lx, ly;
      logic [1:0]      t;
      bit              take_x;
      mx = vx;
      my = vy;
      if (vx == 0 && vy == 0) return OC_NONE;
      if (!axis_open(px, sx, vx, cols, ax)) return OC_NONE;
      if (!axis_open(py, sy, vy, rows, ay)) return OC_NONE;
      while (ax.reach || ay.reach) begin
         nx = line_gap(ax);
         ny = line_gap(ay);
         if (ax.reach && ay.reach) begin
            lx = nx * ay.av;
            ly = ny * ax.av;
            // front sits on a grid corner: test the diagonal tile
            if (nx == 0 && ny == 0) begin
               t = tile_at(ax.idx, ay.idx);
               if (t == KIND_SOLID || (t == KIND_ONEWAY && vy > 0)) begin
                  mx = ax.front - ax.orig;
                  my = ay.front - ay.orig;
                  return pref ? OC_VLINE : OC_HLINE;
               end
            end
            take_x = (lx < ly) || (lx == ly && pref);
         end else begin
            take_x = ax.reach;
         end
         if (take_x) begin
            slide(ay, nx, ax.av);
            ax.front = ax.line * ONE;
            span_of(ay, rows, lo, hi);
            for (longint k = lo; k <= hi; k++) begin
               if (tile_at(ax.idx, k) == KIND_SOLID) begin
                  mx = ax.front - ax.orig;
                  my = ay.front - ay.orig;
                  return OC_VLINE;
               end
            end
            step_line(ax);
         end else begin
            slide(ax, ny, ay.av);
            ay.front = ay.line * ONE;
            span_of(ax, cols, lo, hi);
            for (longint k = lo; k <= hi; k++) begin
               t = tile_at(k, ay.idx);
               if (t == KIND_SOLID || (t == KIND_ONEWAY && vy > 0)) begin
                  mx = ax.front - ax.orig;
                  my = ay.front - ay.orig;
                  return OC_HLINE;
               end
            end
            step_line(ay);
         end
      end
      mx = vx;
      my = vy;
      return OC_NONE;
   endfunction

   // expected response word for one request word
   function automatic clip_word_t predict_word(logic [1:0] act, logic [REQ_W-1:0] d);
      clip_word_t w;
      logic [5:0] cx, cy;
      logic [1:0] kd;
      longint     mx, my;
      cx = d[5:0];
      cy = d[11:6];
      kd = d[13:12];
      w  = '{default: 0};
      case (act)
         ACT_WRITE: begin
            if (cx < cols && cy < rows) tiles[cy][cx] = (kd == KIND_BAD) ? KIND_EMPTY : kd;
         end
         ACT_READ: w.kind = tile_at(cx, cy);
         ACT_CLIP: begin
            w.oc = clip_sweep(longint'($signed(d[45:14])), longint'($signed(d[77:46])),
                              longint'(d[108:78]), longint'(d[139:109]),
                              longint'($signed(d[171:140])), longint'($signed(d[203:172])),
                              d[204], mx, my);
            w.mx = mx[31:0];
            w.my = my[31:0];
         end
         default: ;
      endcase
      return w;
   endfunction

   function automatic longint grid_size(logic [CFG_W-1:0] v, longint lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
   endfunction

   clip_word_t got, want;

   always @(posedge clock) begin
      if (reset) begin
         foreach (tiles[y, x]) tiles[y][x] = KIND_EMPTY;
         cols = MAX_WIDTH_DEF;
         rows = MAX_HEIGHT_DEF;
         expected_q.delete();
         errors = 0;
      end else begin
         // register writes
         if (csr_we) begin
            if (csr_addr == REG_WIDTH) cols = grid_size(csr_wdata, MAX_WIDTH_DEF);
            else rows = grid_size(csr_wdata, MAX_HEIGHT_DEF);
         end
         // accepted request word
         if (req_tvalid && req_tready) expected_q.push_back(predict_word(req_tuser, req_tdata));
         // accepted response word
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tdata[1:0];
            got.mx   = rsp_tdata[33:2];
            got.my   = rsp_tdata[65:34];
            got.oc   = rsp_tdata[67:66];
            if (expected_q.size() == 0) begin
               $display("%0t: response word with nothing expected, got %h", $realtime,
                        rsp_tdata);
               errors++;
            end else begin
               want = expected_q.pop_front();
               if (got.kind != want.kind) begin
                  $display("%0t: read_kind expected %0d got %0d", $realtime, want.kind,
                           got.kind);
                  errors++;
               end
               if (got.mx != want.mx) begin
                  $display("%0t: move_x expected %h got %h", $realtime, want.mx, got.mx);
                  errors++;
               end
               if (got.my != want.my) begin
                  $display("%0t: move_y expected %h got %h", $realtime, want.my, got.my);
                  errors++;
               end
               if (got.oc != want.oc) begin
                  $display("%0t: outcome expected %0d got %0d", $realtime, want.oc, got.oc);
                  errors++;
               end
            end
         end
      end
      pending = expected_q.size();
   end

endmodule

>>> tb/sv/swept_box_tile_grid_clip_tb.sv
`timescale 1ns / 100ps
// swept_box_tile_grid_clip_tb: drives tile writes, reads and clip queries through
// several grid sizes; depends on sbc_pkg, the block and swept_box_tile_grid_clip_chk

module swept_box_tile_grid_clip_tb;
   import sbc_pkg::*;

   localparam int         CYCLE_LIMIT = 8000000;
   localparam longint     ONE         = 64'sd1 <<< FRAC_BITS_DEF;
   localparam logic [1:0] ACT_SPARE   = 2'd3;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   // cell_x, cell_y, cell_kind, pos_x, pos_y, size_x, size_y, vel_x, vel_y,
   // prefer_vertical, zero fill
   logic [REQ_W-1:0] req_tdata;
   // action
   logic [1:0]       req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   // read_kind, move_x, move_y, outcome, zero fill
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_we;
   logic [0:0]       csr_addr;
   logic [CFG_W-1:0] csr_wdata;
   int               errors;
   int               pending;
   int               cycles;
   int               hold_asks;
   int               burst_left;
   int               cols, rows;

   swept_box_tile_grid_clip dut (.*);

   swept_box_tile_grid_clip_chk chk (.*);

   // clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("swept_box_tile_grid_clip_tb: FAIL");
         $finish;
      end
   end

   // response side: one of four stall patterns per random span, long hold on ask
   initial begin
      int mode, hold_seen, span;
      rsp_tready = 1'b0;
      hold_seen  = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(50, 300);
         for (int i = 0; i < span; i++) begin
            @(posedge clock);
            if (hold_asks != hold_seen) begin
               hold_seen = hold_asks;
               rsp_tready <= 1'b0;
               repeat (600) @(posedge clock);
            end
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 1);
               2: rsp_tready <= ($urandom_range(0, 7) == 0);
               default: rsp_tready <= ((i % 5) != 0);
            endcase
         end
      end
   end

   // one request word; random bursts and gaps on the sender side
   task automatic send_word(logic [1:0] act, logic [5:0] cx, logic [5:0] cy,
                            logic [1:0] kd, logic [31:0] px, logic [31:0] py,
                            logic [30:0] sx, logic [30:0] sy, logic [31:0] vx,
                            logic [31:0] vy, logic pref);
      req_tuser  <= act;
      req_tdata  <= {3'b0, pref, vy, vx, sy, sx, py, px, kd, cy, cx};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   task automatic cell_op(logic [1:0] act, int x, int y, logic [1:0] kd);
      send_word(act, 6'(x), 6'(y), kd, '0, '0, '0, '0, '0, '0, 1'b0);
   endtask

   task automatic clip_op(longint px, longint py, longint sx, longint sy, longint vx,
                          longint vy, bit pref);
      send_word(ACT_CLIP, 6'($urandom), 6'($urandom), 2'($urandom), 32'(px), 32'(py),
                31'(sx), 31'(sy), 32'(vx), 32'(vy), pref);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_grid(int w, int h);
      csr_we    <= 1'b1;
      csr_addr  <= REG_WIDTH;
      csr_wdata <= CFG_W'(w);
      @(posedge clock);
      csr_addr  <= REG_HEIGHT;
      csr_wdata <= CFG_W'(h);
      @(posedge clock);
      csr_we    <= 1'b0;
      cols = (w == 0) ? 1 : (w > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : w);
      rows = (h == 0) ? 1 : (h > MAX_HEIGHT_DEF ? MAX_HEIGHT_DEF : h);
   endtask

   // coordinate near the grid, sometimes on a line
   function automatic longint near_coord(int lim);
      longint c;
      c = (longint'($urandom_range(0, lim + 8)) - 4) * ONE;
      if ($urandom_range(0, 2) != 0) c += $urandom_range(0, ONE - 1);
      return c;
   endfunction

   function automatic longint rand_extent(int hi_cells, bit neg);
      longint c;
      c = longint'($urandom_range(0, hi_cells)) * ONE;
      if ($urandom_range(0, 1)) c += $urandom_range(0, ONE - 1);
      if ($urandom_range(0, 7) == 0) c = 0;
      return (neg && $urandom_range(0, 1)) ? -c : c;
   endfunction

   task automatic random_word(bit allow_noise);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         cell_op(ACT_WRITE, $urandom_range(0, cols + 1) % 64, $urandom_range(0, rows + 1) % 64,
                 ($urandom_range(0, 9) == 0) ? KIND_BAD : 2'($urandom_range(0, 2)));
      end else if (pick < 48) begin
         cell_op(ACT_READ, $urandom_range(0, 63), $urandom_range(0, 63), 2'($urandom));
      end else if (pick < 96 || !allow_noise) begin
         clip_op(near_coord(cols), near_coord(rows), rand_extent(3, 1'b0),
                 rand_extent(3, 1'b0), rand_extent(6, 1'b1), rand_extent(6, 1'b1),
                 1'($urandom_range(0, 1)));
      end else begin
         // noise: every bit of every field, unused action included
         send_word(2'($urandom), 6'($urandom), 6'($urandom), 2'($urandom), 32'($urandom),
                   32'($urandom), 31'($urandom), 31'($urandom), 32'($urandom),
                   32'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      int w_set [6] = '{64, 1, 8, 127, 0, 3};
      int h_set [6] = '{64, 1, 5, 0, 64, 127};
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ACT_WRITE;
      csr_we     = 1'b0;
      csr_addr   = REG_WIDTH;
      csr_wdata  = '0;
      hold_asks  = 0;
      burst_left = 0;
      cols       = MAX_WIDTH_DEF;
      rows       = MAX_HEIGHT_DEF;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_grid(64, 64);

      // directed: writes, reads, unused action, bad kind
      cell_op(ACT_WRITE, 2, 2, KIND_SOLID);
      cell_op(ACT_WRITE, 5, 1, KIND_ONEWAY);
      cell_op(ACT_WRITE, 63, 63, KIND_BAD);
      cell_op(ACT_WRITE, 0, 0, KIND_SOLID);
      cell_op(ACT_READ, 2, 2, KIND_EMPTY);
      cell_op(ACT_READ, 5, 1, KIND_EMPTY);
      cell_op(ACT_READ, 63, 63, KIND_EMPTY);
      send_word(ACT_SPARE, 6'd2, 6'd2, KIND_SOLID, 32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF,
                31'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
      // zero velocity, sweep missing the grid, extremes
      clip_op(ONE, ONE, ONE, ONE, 0, 0, 0);
      clip_op(-10 * ONE, ONE, ONE, ONE, -ONE, ONE, 0);
      clip_op(32'sh80000000, 32'sh80000000, 31'h7FFFFFFF, 31'h7FFFFFFF,
              32'sh7FFFFFFF, 32'sh7FFFFFFF, 1);
      clip_op(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 32'sh80000000, 32'sh80000000, 0);
      // front on a grid corner, both preferences
      clip_op(ONE, ONE, ONE, ONE, ONE, ONE, 1);
      clip_op(ONE, ONE, ONE, ONE, ONE, ONE, 0);
      // one-way tile: stops going up, not going down or sideways
      clip_op(5 * ONE, 0, ONE / 2, ONE / 2, 0, 2 * ONE, 0);
      clip_op(5 * ONE, 3 * ONE, ONE / 2, ONE / 2, 0, -3 * ONE, 0);
      clip_op(3 * ONE, ONE + ONE / 4, ONE / 2, ONE / 2, 3 * ONE, 0, 1);
      // solid from the side and from above, fractional motion
      clip_op(0, 2 * ONE + ONE / 3, ONE / 2, ONE / 2, 3 * ONE + 5, ONE / 7, 0);
      clip_op(2 * ONE + ONE / 4, 5 * ONE, ONE / 3, ONE, -ONE / 9, -4 * ONE, 1);
      // long sweep across an empty grid to the far edge
      clip_op(-3 * ONE, 10 * ONE, ONE, ONE, 80 * ONE, ONE / 2, 0);
      wait_idle();

      // random phases over several grid sizes
      foreach (w_set[p]) begin
         set_grid(w_set[p], h_set[p]);
         for (int i = 0; i < 250; i++) begin
            if (i == 120 && p == 1) hold_asks++;
            if (i == 125 && p == 2) wait_idle();
            random_word(cols <= 8 || rows <= 8);
         end
         wait_idle();
      end

      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("swept_box_tile_grid_clip_tb: PASS");
      end else begin
         $display("swept_box_tile_grid_clip_tb: FAIL");
      end
      $finish;
   end

endmodule
